@@ src/utf8d_pkg.sv @@
package utf8d_pkg;

  localparam int unsigned CpWidth = 21;

  localparam logic [CpWidth-1:0] ReplacementReset = 21'h00FFFD;
  localparam logic [CpWidth-1:0] ByteOrderMark    = 21'h00FEFF;

  localparam logic CFG_REPLACEMENT_VALUE     = 1'b0;
  localparam logic CFG_STRIP_BYTE_ORDER_MARK = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic [CpWidth-1:0] code_point;
    logic               was_invalid;
    logic               last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [CpWidth-1:0] partial_value;
    logic [1:0]         bytes_still_needed;
    logic [1:0]         bytes_consumed;
    logic [1:0]         minimum_class;
    logic               header_done;
  } seq_state_t;

  // Results of one request: bad_count replacements, then an optional decoded value.
  typedef struct packed {
    logic [2:0]         bad_count;
    logic               good;
    logic [CpWidth-1:0] value;
  } burst_t;

  function automatic logic [CpWidth-1:0] class_minimum(input logic [1:0] cls);
    logic [CpWidth-1:0] m;
    case (cls)
      2'd1:    m = 21'h000080;
      2'd2:    m = 21'h000800;
      2'd3:    m = 21'h010000;
      default: m = 21'h000000;
    endcase
    return m;
  endfunction

  function automatic logic bad_value(input logic [CpWidth-1:0] v, input logic [1:0] cls);
    logic overlong;
    logic surrogate;
    logic nonchar;
    logic too_large;
    overlong  = v < class_minimum(cls);
    surrogate = (v >= 21'h00D800) && (v <= 21'h00DFFF);
    nonchar   = ((v >= 21'h00FDD0) && (v <= 21'h00FDEF)) || (v[15:1] == 15'h7FFF);
    too_large = v >= 21'h110000;
    return overlong || surrogate || nonchar || too_large;
  endfunction

endpackage

@@ src/utf8d_decode.sv @@
module utf8d_decode
  import utf8d_pkg::*;
(
  input  seq_state_t seq,
  input  in_item_t   item,
  input  logic       strip_bom,
  output seq_state_t seq_next,
  output burst_t     res
);

  logic [CpWidth-1:0] pv_shift;
  logic               is_cont;
  logic               do_fresh;
  logic [7:0]         b;
  seq_state_t         s;
  burst_t             r;

  assign b        = item.data_byte;
  assign is_cont  = b[7:6] == 2'b10;
  assign pv_shift = {seq.partial_value[CpWidth-7:0], b[5:0]};

  always_comb begin
    s        = seq;
    r        = '0;
    do_fresh = 1'b0;

    if (seq.bytes_still_needed != 2'd0) begin
      if (is_cont) begin
        if (seq.bytes_still_needed == 2'd1) begin
          if (strip_bom && !seq.header_done && pv_shift == ByteOrderMark) begin
            r = '0;
          end else if (bad_value(pv_shift, seq.minimum_class)) begin
            r.bad_count = 3'd1;
          end else begin
            r.good  = 1'b1;
            r.value = pv_shift;
          end
          s             = '0;
          s.header_done = 1'b1;
        end else begin
          s.partial_value      = pv_shift;
          s.bytes_still_needed = seq.bytes_still_needed - 2'd1;
          s.bytes_consumed     = seq.bytes_consumed + 2'd1;
        end
      end else begin
        // A broken sequence is replaced byte by byte, then the byte starts over.
        r.bad_count   = 3'd1 + {1'b0, seq.bytes_consumed};
        s             = '0;
        s.header_done = 1'b1;
        do_fresh      = 1'b1;
      end
    end else begin
      do_fresh = 1'b1;
    end

    if (do_fresh) begin
      if (!b[7]) begin
        r.good        = 1'b1;
        r.value       = {13'd0, b};
        s.header_done = 1'b1;
      end else if (b[7:5] == 3'b110) begin
        s.partial_value      = {16'd0, b[4:0]};
        s.bytes_still_needed = 2'd1;
        s.minimum_class      = 2'd1;
        s.bytes_consumed     = 2'd0;
        s.header_done        = 1'b1;
      end else if (b[7:4] == 4'b1110) begin
        s.partial_value      = {17'd0, b[3:0]};
        s.bytes_still_needed = 2'd2;
        s.minimum_class      = 2'd2;
        s.bytes_consumed     = 2'd0;
      end else if (b[7:3] == 5'b11110) begin
        s.partial_value      = {18'd0, b[2:0]};
        s.bytes_still_needed = 2'd3;
        s.minimum_class      = 2'd3;
        s.bytes_consumed     = 2'd0;
        s.header_done        = 1'b1;
      end else begin
        r.bad_count   = r.bad_count + 3'd1;
        s.header_done = 1'b1;
      end
    end

    if (item.end_of_stream) begin
      if (s.bytes_still_needed != 2'd0) begin
        r.bad_count = r.bad_count + 3'd1 + {1'b0, s.bytes_consumed};
      end
      s = '0;
    end

    seq_next = s;
    res      = r;
  end

endmodule

@@ src/utf8_to_code_point_decoder.sv @@
// UTF-8 byte stream to Unicode code point decoder.
// Input channel: in_valid / in_stall carry one byte and an end-of-stream mark.
// Output channel: out_valid / out_stall carry one code point per request, with
// a flag for replacements and a mark on the last result caused by each byte.
// Configuration: cfg_write with cfg_index 0 sets the replacement value and
// index 1 the byte order mark stripping; write only while the block is idle.
// A byte is held in an input register, decoded combinationally and its results
// are loaded into a result register once that register is free, from which the
// first result is offered. One byte a cycle is sustained while each byte gives
// at most one result and the receiver does not stall.
// A byte that gives k results (up to four, for broken sequences and
// end-of-stream flushes) holds the result register until all k are taken, while
// the input register takes the next byte.
// When the receiver stalls, the current result holds, the next byte waits in
// the input register and in_stall rises once that register is full.
// Reset clears the sequence state and both valid flags, and sets the
// replacement value to U+FFFD with stripping enabled.
module utf8_to_code_point_decoder
  import utf8d_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_item,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [CpWidth-1:0] cfg_data
);

  logic               in_full;
  in_item_t           in_hold;
  seq_state_t         seq;
  seq_state_t         seq_next;
  burst_t             burst;
  burst_t             dec_res;
  logic [CpWidth-1:0] replacement_value;
  logic               strip_bom;
  logic               last;
  logic               out_take;
  logic               burst_free;
  logic               in_move;

  utf8d_decode u_decode (
    .seq      (seq),
    .item     (in_hold),
    .strip_bom(strip_bom),
    .seq_next (seq_next),
    .res      (dec_res)
  );

  assign out_valid  = (burst.bad_count != 3'd0) || burst.good;
  assign last       = (burst.bad_count == 3'd1 && !burst.good) ||
                      (burst.bad_count == 3'd0 && burst.good);
  assign out_take   = out_valid && !out_stall;
  assign burst_free = !out_valid || (out_take && last);
  assign in_move    = in_full && burst_free;
  assign in_stall   = in_full && !burst_free;

  assign out_item.code_point  = (burst.bad_count != 3'd0) ? replacement_value : burst.value;
  assign out_item.was_invalid = burst.bad_count != 3'd0;
  assign out_item.last_of_run = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (in_move) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_hold <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= '0;
    end else if (in_move) begin
      seq <= seq_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      burst <= '0;
    end else if (in_move) begin
      burst <= dec_res;
    end else if (out_take) begin
      if (burst.bad_count != 3'd0) begin
        burst.bad_count <= burst.bad_count - 3'd1;
      end else begin
        burst.good <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      replacement_value <= ReplacementReset;
      strip_bom         <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_REPLACEMENT_VALUE:     replacement_value <= cfg_data;
        CFG_STRIP_BYTE_ORDER_MARK: strip_bom         <= cfg_data[0];
      endcase
    end
  end

  // An open sequence never has more bytes due and taken than a four-byte form allows.
  assert property (@(posedge clk) disable iff (rst)
    {1'b0, seq.bytes_still_needed} + {1'b0, seq.bytes_consumed} <= 3'd3)
    else $error("Sequence byte counts exceed a four-byte form.");

  // An open sequence always has a minimum class.
  assert property (@(posedge clk) disable iff (rst)
    (seq.bytes_still_needed != 2'd0) |-> (seq.minimum_class != 2'd0))
    else $error("Open sequence without a minimum class.");

  // A request never produces more than four results.
  assert property (@(posedge clk) disable iff (rst)
    ({1'b0, burst.bad_count} + {3'd0, burst.good}) <= 4'd4)
    else $error("Result burst longer than four.");

  // Each taken replacement that is not the last one counts the burst down by one.
  assert property (@(posedge clk) disable iff (rst)
    (out_take && !in_move && burst.bad_count > 3'd1) |=>
      (burst.bad_count == $past(burst.bad_count) - 3'd1))
    else $error("Replacement count did not step down.");

  // A byte leaves the input register only when the result register is free.
  assert property (@(posedge clk) disable iff (rst)
    in_move |-> (!out_valid || (out_take && last)))
    else $error("Result overwritten before it was delivered.");

  // Reset leaves no sequence open.
  assert property (@(posedge clk)
    (!rst && $past(rst)) |-> (seq.bytes_still_needed == 2'd0 && !out_valid))
    else $error("State not cleared by reset.");

endmodule
